[hdl/sha_pkg.sv]
// shared types, round constants and initial hash values of the sha-256 hasher
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // classified request held in the queue between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
  } q_entry_t;

  typedef struct packed {
    logic start;
    logic init;
  } comp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic start;
  } back_status_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LEN_OFFSET = 7'd56;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  function automatic logic [31:0] init_word(input logic [2:0] i);
    logic [31:0] v;
    unique case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[hdl/sha256_stream_hasher.sv]
// top level of the byte-serial sha-256 hasher
// Byte-serial SHA-256 hasher. Each request carries one message byte (byte_valid) and may
// end the message (last_byte); a request with neither is dropped. Requests enter a short
// queue and are taken at up to one per cycle into a 64-byte block buffer; a full block
// goes to the round engine (load, 64 rounds, chaining add), and the buffer refills
// during compression. On the end of a message the back end inserts 9 to 72 padding
// and length bytes at one per cycle while the buffer has room, waits for the final
// compression, then presents the eight digest words, index 0 first, one per pop; the
// next message may already stream in while the words are drained. The hasher then
// starts again from the initial vector.
`default_nettype none
module sha256_stream_hasher #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sha_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::out_item_t result
);
  import sha_pkg::*;

  logic         q_valid;
  q_entry_t     q_data;
  logic         q_pop;
  back_status_t status;

  sha_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  sha_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .status  (status)
  );

  // the engine is never restarted mid-block
  assert property (@(posedge clk) disable iff (rst) status.start |-> !status.busy)
    else $error("round engine started while busy");

  // words come out in order without gaps
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last_word) |=>
      (!empty && result.word_index == 3'($past(result.word_index) + 3'd1)))
    else $error("digest word order broken");

  // a new digest never follows the last word in the very next cycle
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.last_word) |=> empty)
    else $error("digest output not drained after last word");

  // the queue only hands over requests it holds
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

[hdl/sha_front.sv]
// input side: accepts requests, drops empty ones, queues the rest for the back end
`default_nettype none
module sha_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sha_pkg::in_item_t item,
  output logic              q_valid,
  output sha_pkg::q_entry_t q_data,
  input  logic              q_pop
);
  import sha_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t          slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              keep;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];
  // a request that is neither a byte nor an end leaves no trace
  assign keep    = push && !full && (item.byte_valid || item.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (keep && !q_pop) begin
        count <= count + 1'b1;
      end else if (!keep && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      slots[wr_ptr].data     <= item.data_byte;
      slots[wr_ptr].has_byte <= item.byte_valid;
      slots[wr_ptr].is_last  <= item.last_byte;
    end
  end

endmodule
`default_nettype wire

[hdl/sha_compress.sv]
// sha-256 round engine: one round per cycle plus a chaining add
`default_nettype none
module sha_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  sha_pkg::comp_ctrl_t  ctrl,
  input  logic [511:0]         block,
  output logic                 busy,
  output logic [7:0][31:0]     chain
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } cstate_t;

  cstate_t     state;
  logic [5:0]  round;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign busy = (state != C_IDLE);

  always_comb begin
    w_new = w[0]
          + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3))
          + w[9]
          + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(round) + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_word(3'(i));
      end
    end else begin
      unique case (state)
        C_IDLE: begin
          if (ctrl.init) begin
            for (int i = 0; i < 8; i++) begin
              chain[i] <= init_word(3'(i));
            end
          end
          if (ctrl.start) begin
            round <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctrl.start) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32 * i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (state == C_ROUND) begin
      // w[0] is always the schedule word of the current round
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

[hdl/sha_back.sv]
// back end: block buffer, padding sequencer, round engine hookup and digest output
`default_nettype none
module sha_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  sha_pkg::q_entry_t     q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output sha_pkg::out_item_t    result,
  output sha_pkg::back_status_t status
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    B_RUN    = 5'b00001,
    B_PAD80  = 5'b00010,
    B_PADZ   = 5'b00100,
    B_LEN    = 5'b01000,
    B_FINISH = 5'b10000
  } bstate_t;

  bstate_t          state;
  bstate_t          state_next;
  logic [6:0]       fill;
  logic [511:0]     blk_buf;
  logic [60:0]      msg_count;
  logic [2:0]       len_idx;
  logic [63:0]      len_bits;
  logic [7:0][31:0] dig;
  logic [2:0]       out_idx;
  logic             out_busy;

  logic             comp_busy;
  logic [7:0][31:0] chain;
  comp_ctrl_t       ctrl;
  logic             start_now;
  logic             finish_now;
  logic             can_push;
  logic             push_en;
  logic [7:0]       push_byte;
  logic             count_inc;

  sha_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .block (blk_buf),
    .busy  (comp_busy),
    .chain (chain)
  );

  // a full buffer hands off to the idle engine and can take a byte in the same cycle
  assign start_now  = (fill == BLOCK_BYTES) && !comp_busy;
  assign can_push   = (fill != BLOCK_BYTES) || start_now;
  assign ctrl.start = start_now;
  assign ctrl.init  = finish_now;
  assign len_bits   = {msg_count, 3'b000};

  always_comb begin
    state_next = state;
    push_en    = 1'b0;
    push_byte  = '0;
    q_pop      = 1'b0;
    count_inc  = 1'b0;
    finish_now = 1'b0;
    unique case (state)
      B_RUN: begin
        if (q_valid) begin
          if (q_data.has_byte) begin
            if (can_push) begin
              push_en   = 1'b1;
              push_byte = q_data.data;
              q_pop     = 1'b1;
              count_inc = 1'b1;
              if (q_data.is_last) begin
                state_next = B_PAD80;
              end
            end
          end else begin
            q_pop = 1'b1;
            if (q_data.is_last) begin
              state_next = B_PAD80;
            end
          end
        end
      end
      B_PAD80: begin
        if (can_push) begin
          push_en    = 1'b1;
          push_byte  = PAD_BYTE;
          state_next = B_PADZ;
        end
      end
      B_PADZ: begin
        if (fill == LEN_OFFSET) begin
          state_next = B_LEN;
        end else if (can_push) begin
          push_en = 1'b1;
        end
      end
      B_LEN: begin
        if (can_push) begin
          push_en   = 1'b1;
          // big-endian bit length, top byte first
          push_byte = 8'(len_bits >> {3'd7 - len_idx, 3'b000});
          if (len_idx == 3'd7) begin
            state_next = B_FINISH;
          end
        end
      end
      B_FINISH: begin
        // fill is zero only once the last block went to the engine
        if (fill == '0 && !comp_busy && !out_busy) begin
          finish_now = 1'b1;
          state_next = B_RUN;
        end
      end
      default: state_next = B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_RUN;
      fill      <= '0;
      msg_count <= '0;
      len_idx   <= '0;
      out_idx   <= '0;
      out_busy  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= (start_now ? 7'd0 : fill) + {6'd0, push_en};
      if (finish_now) begin
        msg_count <= '0;
      end else if (count_inc) begin
        msg_count <= msg_count + 1'b1;
      end
      if (state == B_LEN && push_en) begin
        len_idx <= len_idx + 1'b1;
      end
      if (finish_now) begin
        out_idx  <= '0;
        out_busy <= 1'b1;
      end else if (pop && out_busy) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == 3'd7) begin
          out_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      blk_buf <= {blk_buf[503:0], push_byte};
    end
    if (finish_now) begin
      dig <= chain;
    end else if (pop && out_busy) begin
      dig <= {dig[0], dig[7:1]};
    end
  end

  assign empty              = !out_busy;
  assign result.digest_word = dig[0];
  assign result.word_index  = out_idx;
  assign result.last_word   = (out_idx == 3'd7);
  assign status.busy        = comp_busy;
  assign status.start       = start_now;

endmodule
`default_nettype wire
